@@ hw/rtl/sha1sh_pkg.sv @@
// Package with the SHA-1 constants and the round function.
`default_nettype none
package sha1sh_pkg;

  localparam logic [31:0] H0Init = 32'h67452301;
  localparam logic [31:0] H1Init = 32'hefcdab89;
  localparam logic [31:0] H2Init = 32'h98badcfe;
  localparam logic [31:0] H3Init = 32'h10325476;
  localparam logic [31:0] H4Init = 32'hc3d2e1f0;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [7:0] PadByte = 8'h80;
  localparam int unsigned NumRounds = 80;
  localparam int unsigned NumDigestWords = 5;

  // Round constant for a round number.
  function automatic logic [31:0] round_k(input logic [6:0] t);
    logic [31:0] k;
    begin
      if (t < 7'd20) k = K0;
      else if (t < 7'd40) k = K1;
      else if (t < 7'd60) k = K2;
      else k = K3;
      return k;
    end
  endfunction

  // Boolean function of a round.
  function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    begin
      if (t < 7'd20) f = (b & c) ^ (~b & d);
      else if (t < 7'd40 || t >= 7'd60) f = b ^ c ^ d;
      else f = (b & c) ^ (b & d) ^ (c & d);
      return f;
    end
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/sha1_stream_hasher_top.sv @@
// SHA-1 stream hasher: byte buffer memory, schedule memory and round engine.
`default_nettype none
// Each transfer carries at most one message byte and may close the message.
// A byte that does not complete a 64-byte block goes into the byte memory,
// and the next transfer may follow at once. The 64th byte, and every close,
// start the compression engine. It loads the schedule window from the byte
// memory through its one registered read port. In each of the first 16
// rounds it reads a stored word and then uses it; in each of the other 64
// the four schedule taps are read one per cycle and the round completes when
// the last tap arrives. It then updates the chaining words. A close first
// writes the 0x80 byte, the zero fill and the eight length bytes at one byte
// per cycle, needs one or two compressions, and then makes five digest
// transfers, one per cycle unless stalled. Input is stalled while any of
// this work is in progress.
module sha1_stream_hasher_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire  [7:0]  data_byte_i,
  input  wire         has_byte_i,
  input  wire         end_of_message_i,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o,
  output logic        out_valid_o,
  input  wire         out_stall_i
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StPad80 = 4'd1;
  localparam logic [3:0] StZero  = 4'd2;
  localparam logic [3:0] StLen   = 4'd3;
  localparam logic [3:0] StLoad  = 4'd4;
  localparam logic [3:0] StRound = 4'd5;
  localparam logic [3:0] StFinal = 4'd6;
  localparam logic [3:0] StOut   = 4'd7;

  logic [3:0]  state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bits_q, bits_d;
  logic        closing_q, closing_d;  // message close in progress
  logic        padded_q, padded_d;    // the 0x80 byte is already placed
  logic        lenblk_q, lenblk_d;    // current compression is the final one
  logic [6:0]  cnt_q, cnt_d;
  logic [2:0]  oidx_q, oidx_d;
  logic [31:0] h_q [5];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] a_d, b_d, c_d, d_d, e_d;
  logic        hupd;

  // Byte buffer memory.
  logic [7:0]  bmem [64];
  logic        bwe;
  logic [5:0]  bwa, bra;
  logic [7:0]  bwd, brd_q;

  always_ff @(posedge clk_i) begin
    if (bwe) begin
      bmem[bwa] <= bwd;
    end
    brd_q <= bmem[bra];
  end

  // Schedule window memory.
  logic [31:0] wmem [16];
  logic        wwe;
  logic [3:0]  wwa, wra;
  logic [31:0] wwd, wrd_q;

  always_ff @(posedge clk_i) begin
    if (wwe) begin
      wmem[wwa] <= wwd;
    end
    wrd_q <= wmem[wra];
  end

  // Load phase: cnt counts byte reads 0..64; assembly register collects words.
  logic [31:0] asm_q, asm_d;
  logic [5:0]  ld_prev;
  assign ld_prev = cnt_q[5:0] - 6'd1;

  // Schedule expansion: four taps are read over a sub-step counter per round.
  logic [1:0]  sub_q, sub_d;
  logic [31:0] wx_q, wx_d;
  logic [3:0]  s_idx;
  logic [31:0] wt, tmp;
  assign s_idx = cnt_q[3:0];

  always_comb begin
    state_d = state_q; fill_d = fill_q; bits_d = bits_q;
    closing_d = closing_q; padded_d = padded_q; lenblk_d = lenblk_q;
    cnt_d = cnt_q; oidx_d = oidx_q;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q; e_d = e_q;
    asm_d = asm_q; sub_d = sub_q; wx_d = wx_q;
    bwe = 1'b0; bwa = fill_q; bwd = data_byte_i; bra = 6'd0;
    wwe = 1'b0; wwa = 4'd0; wwd = '0; wra = 4'd0;
    hupd = 1'b0; wt = '0; tmp = '0;
    in_stall_o = 1'b1;
    case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (has_byte_i) begin
            bwe = 1'b1;
            fill_d = fill_q + 6'd1;
            bits_d = bits_q + 64'd8;
          end
          closing_d = end_of_message_i;
          padded_d = 1'b0;
          if (has_byte_i && fill_q == 6'd63) begin
            lenblk_d = 1'b0;
            cnt_d = '0;
            state_d = StLoad;
          end else if (end_of_message_i) begin
            state_d = StPad80;
          end
        end
      end
      StPad80: begin
        bwe = 1'b1; bwd = sha1sh_pkg::PadByte; bwa = fill_q;
        fill_d = fill_q + 6'd1;
        padded_d = 1'b1;
        if (fill_q == 6'd63) begin
          lenblk_d = 1'b0; cnt_d = '0; state_d = StLoad;
        end else begin
          state_d = StZero;
        end
      end
      StZero: begin
        // Zero up to 56 when there is room, else to 64 and compress first.
        if (fill_q == 6'd56) begin
          cnt_d = '0; state_d = StLen;
        end else begin
          bwe = 1'b1; bwd = 8'd0; bwa = fill_q;
          fill_d = fill_q + 6'd1;
          if (fill_q == 6'd63) begin
            lenblk_d = 1'b0; cnt_d = '0; state_d = StLoad;
          end
        end
      end
      StLen: begin
        bwe = 1'b1; bwa = {3'b111, cnt_q[2:0]};
        bwd = bits_q[63 - {cnt_q[2:0], 3'b000} -: 8];
        cnt_d = cnt_q + 7'd1;
        if (cnt_q[2:0] == 3'd7) begin
          lenblk_d = 1'b1; cnt_d = '0; state_d = StLoad;
        end
      end
      StLoad: begin
        bra = cnt_q[5:0];
        if (cnt_q != 7'd0) begin
          asm_d = {asm_q[23:0], brd_q};
          if (ld_prev[1:0] == 2'd3) begin
            wwe = 1'b1; wwa = ld_prev[5:2]; wwd = {asm_q[23:0], brd_q};
          end
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd64) begin
          cnt_d = '0; sub_d = '0;
          a_d = h_q[0]; b_d = h_q[1]; c_d = h_q[2]; d_d = h_q[3]; e_d = h_q[4];
          state_d = StRound;
        end
      end
      StRound: begin
        if (cnt_q < 7'd16) begin
          // Read the stored word, use it next cycle.
          wra = s_idx;
          sub_d = sub_q + 2'd1;
          if (sub_q == 2'd1) begin
            wt = wrd_q;
            sub_d = '0;
          end
        end else begin
          // Four reads, one per cycle; the last tap arrives in the round cycle.
          case (sub_q)
            2'd0: begin wra = s_idx + 4'd13; end
            2'd1: begin wra = s_idx + 4'd8; wx_d = wrd_q; end
            2'd2: begin wra = s_idx + 4'd2; wx_d = wx_q ^ wrd_q; end
            default: begin wra = s_idx; wx_d = wx_q ^ wrd_q; end
          endcase
          sub_d = sub_q + 2'd1;
        end
        if (sub_q == 2'd1 && cnt_q < 7'd16) begin
          tmp = {a_q[26:0], a_q[31:27]} + sha1sh_pkg::round_f(cnt_q, b_q, c_q, d_q)
                + e_q + sha1sh_pkg::round_k(cnt_q) + wt;
          e_d = d_q; d_d = c_q; c_d = {b_q[1:0], b_q[31:2]}; b_d = a_q; a_d = tmp;
          cnt_d = cnt_q + 7'd1;
        end
        if (cnt_q >= 7'd16 && sub_q == 2'd3) begin
          sub_d = sub_q;  // hold the sub-step; the round completes in StFinal with the last tap
          state_d = StFinal;
        end
      end
      StFinal: begin
        if (cnt_q == 7'(sha1sh_pkg::NumRounds)) begin
          hupd = 1'b1;
          fill_d = '0;
          if (lenblk_q) begin
            oidx_d = '0; state_d = StOut;
          end else if (closing_q && padded_q) begin
            // Second block: zero from 0 to 56 then length.
            state_d = StZero;
          end else if (closing_q) begin
            // The block filled on the closing byte: the 0x80 starts a new one.
            state_d = StPad80;
          end else begin
            state_d = StIdle;
          end
        end else begin
          // Finish the expanded word: last tap is on the read port now.
          wt = {wx_q[30:0] ^ wrd_q[30:0], wx_q[31] ^ wrd_q[31]};
          wwe = 1'b1; wwa = s_idx; wwd = wt;
          tmp = {a_q[26:0], a_q[31:27]} + sha1sh_pkg::round_f(cnt_q, b_q, c_q, d_q)
                + e_q + sha1sh_pkg::round_k(cnt_q) + wt;
          e_d = d_q; d_d = c_q; c_d = {b_q[1:0], b_q[31:2]}; b_d = a_q; a_d = tmp;
          cnt_d = cnt_q + 7'd1; sub_d = '0;
          state_d = (cnt_q == 7'd79) ? StFinal : StRound;
        end
      end
      StOut: begin
        if (!out_stall_i) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'(sha1sh_pkg::NumDigestWords - 1)) begin
            state_d = StIdle; fill_d = '0; bits_d = '0; closing_d = 1'b0;
            padded_d = 1'b0;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; fill_q <= '0; bits_q <= '0; closing_q <= 1'b0;
      padded_q <= 1'b0;
      lenblk_q <= 1'b0; cnt_q <= '0; oidx_q <= '0; sub_q <= '0;
      h_q[0] <= sha1sh_pkg::H0Init; h_q[1] <= sha1sh_pkg::H1Init;
      h_q[2] <= sha1sh_pkg::H2Init; h_q[3] <= sha1sh_pkg::H3Init;
      h_q[4] <= sha1sh_pkg::H4Init;
    end else begin
      state_q <= state_d; fill_q <= fill_d; bits_q <= bits_d; closing_q <= closing_d;
      padded_q <= padded_d;
      lenblk_q <= lenblk_d; cnt_q <= cnt_d; oidx_q <= oidx_d; sub_q <= sub_d;
      if (hupd) begin
        h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q; h_q[2] <= h_q[2] + c_q;
        h_q[3] <= h_q[3] + d_q; h_q[4] <= h_q[4] + e_q;
      end else if (state_q == StOut && !out_stall_i && oidx_q == 3'd4) begin
        h_q[0] <= sha1sh_pkg::H0Init; h_q[1] <= sha1sh_pkg::H1Init;
        h_q[2] <= sha1sh_pkg::H2Init; h_q[3] <= sha1sh_pkg::H3Init;
        h_q[4] <= sha1sh_pkg::H4Init;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d; e_q <= e_d;
    asm_q <= asm_d; wx_q <= wx_d;
  end

  // Digest output.
  assign out_valid_o   = (state_q == StOut);
  assign digest_word_o = h_q[(oidx_q > 3'd4) ? 3'd4 : oidx_q];
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 3'd4);

endmodule
`default_nettype wire

@@ hw/rtl/sha1sh_checker.sv @@
// Port-level checker for the SHA-1 stream hasher, with its bind.
`default_nettype none
module sha1sh_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_stall_o,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire [2:0]  word_index_o,
  input wire        last_word_o,
  input wire [31:0] digest_word_o
);

  // Input is held off while a digest is being delivered.
  a_no_in_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open during digest output");

  // The last flag marks word four only.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_word_o == (word_index_o == 3'd4)))
    else $error("last flag wrong");

  // After a completed transfer that is not last, the index advances by one.
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_word_o) |=>
      (out_valid_o && word_index_o == $past(word_index_o) + 3'd1))
    else $error("index did not advance");

  // A stalled digest word holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(digest_word_o)))
    else $error("stalled word changed");

endmodule

bind sha1_stream_hasher_top sha1sh_checker u_chk (.*);
`default_nettype wire

@@ bench/sha1_stream_hasher_top_test.sv @@
// Self-checking testbench for the SHA-1 stream hasher with a behavioral digest predictor.
`timescale 1ns / 100ps
`default_nettype none
module sha1_stream_hasher_top_test;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned RandomItems = 100;

  // One stimulus row; has_check marks a row whose digest is typed in below.
  typedef struct {
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        end_of_message;
    logic        has_check;
    logic [31:0] digest_h0;
  } stim_row_t;

  typedef struct {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_xfer_t;

  logic        clk_i;
  logic        rst_ni;
  logic [7:0]  data_byte_i;
  logic        has_byte_i;
  logic        end_of_message_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;
  logic        out_valid_o;
  logic        out_stall_i;

  sha1_stream_hasher_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .data_byte_i      (data_byte_i),
    .has_byte_i       (has_byte_i),
    .end_of_message_i (end_of_message_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .digest_word_o    (digest_word_o),
    .word_index_o     (word_index_o),
    .last_word_o      (last_word_o),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i)
  );

  // Predictor state: chaining words, block buffer, fill position and bit count.
  logic [31:0]    chain_q [5];
  logic [7:0]     block_q [64];
  int unsigned    fill_q;
  logic [63:0]    bits_q;
  digest_xfer_t   pending_digests[$];
  logic [31:0]    typed_h0[$];
  int unsigned    fail_count;
  int unsigned    digest_count;
  int unsigned    idle_cycles;
  logic           stimulus_done;
  logic           hold_off;
  logic           no_idle;
  stim_row_t      directed_rows[$];
  int unsigned    bound_lens [4];

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // Runs the 80-round compression over the block buffer.
  task automatic compress_buffer();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, tmp, x;
    int unsigned s;
    a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3]; e = chain_q[4];
    for (int t = 0; t < 16; t++) begin
      w[t] = {block_q[4*t], block_q[4*t+1], block_q[4*t+2], block_q[4*t+3]};
    end
    for (int t = 0; t < 80; t++) begin
      s = t % 16;
      if (t >= 16) begin
        x = w[(s + 13) % 16] ^ w[(s + 8) % 16] ^ w[(s + 2) % 16] ^ w[s];
        w[s] = rotl(x, 1);
      end
      if (t < 20) begin
        f = (b & c) ^ (~b & d);
        k = sha1sh_pkg::K0;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = sha1sh_pkg::K1;
      end else if (t < 60) begin
        f = (b & c) ^ (b & d) ^ (c & d);
        k = sha1sh_pkg::K2;
      end else begin
        f = b ^ c ^ d;
        k = sha1sh_pkg::K3;
      end
      tmp = rotl(a, 5) + f + e + k + w[s];
      e = d; d = c; c = rotl(b, 30); b = a; a = tmp;
    end
    chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d; chain_q[4] += e;
  endtask

  task automatic restart_hash();
    chain_q[0] = sha1sh_pkg::H0Init; chain_q[1] = sha1sh_pkg::H1Init;
    chain_q[2] = sha1sh_pkg::H2Init; chain_q[3] = sha1sh_pkg::H3Init;
    chain_q[4] = sha1sh_pkg::H4Init;
    fill_q = 0;
    bits_q = '0;
  endtask

  // Applies one accepted transfer and queues the digest words it causes.
  task automatic absorb_item(input logic [7:0] db, input logic hb, input logic eom);
    digest_xfer_t xfer;
    if (hb) begin
      block_q[fill_q] = db;
      fill_q++;
      bits_q += 64'd8;
      if (fill_q == 64) begin
        compress_buffer();
        fill_q = 0;
      end
    end
    if (eom) begin
      block_q[fill_q] = sha1sh_pkg::PadByte;
      fill_q++;
      if (fill_q > 56) begin
        for (int i = fill_q; i < 64; i++) block_q[i] = '0;
        compress_buffer();
        fill_q = 0;
      end
      for (int i = fill_q; i < 56; i++) block_q[i] = '0;
      for (int i = 0; i < 8; i++) block_q[56 + i] = bits_q[63 - 8*i -: 8];
      compress_buffer();
      for (int i = 0; i < 5; i++) begin
        xfer.digest_word = chain_q[i];
        xfer.word_index  = 3'(i);
        xfer.last_word   = (i == 4);
        pending_digests.push_back(xfer);
      end
      restart_hash();
    end
  endtask

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Drives one transfer and waits until it is accepted.
  task automatic send_item(input logic [7:0] db, input logic hb, input logic eom);
    while (!no_idle && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    data_byte_i      <= db;
    has_byte_i       <= hb;
    end_of_message_i <= eom;
    in_valid_i       <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    absorb_item(db, hb, eom);
  endtask

  task automatic add_row(input logic [7:0] db, input logic hb, input logic eom,
                         input logic chk, input logic [31:0] h0);
    stim_row_t r;
    r.data_byte = db; r.has_byte = hb; r.end_of_message = eom;
    r.has_check = chk; r.digest_h0 = h0;
    directed_rows.push_back(r);
  endtask

  // Sender: directed table, then random well-formed messages with some noise.
  initial begin
    int unsigned sent;
    int unsigned len;
    logic [7:0]  db;
    fail_count = 0; digest_count = 0; stimulus_done = 1'b0; no_idle = 1'b0;
    in_valid_i = 1'b0; data_byte_i = '0; has_byte_i = 1'b0; end_of_message_i = 1'b0;
    rst_ni = 1'b0;
    bound_lens = '{55, 56, 63, 64};
    restart_hash();
    for (int i = 0; i < 64; i++) block_q[i] = '0;
    // Empty message right after reset, with an idle item in front.
    add_row(8'hff, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b1, 1'b1, 32'hda39a3ee);
    // "abc" closed by an empty close.
    add_row("a", 1'b1, 1'b0, 1'b0, '0);
    add_row("b", 1'b1, 1'b0, 1'b0, '0);
    add_row("c", 1'b1, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b1, 1'b1, 32'ha9993e36);
    // Byte extremes with the byte carried on the closing transfer.
    add_row(8'h00, 1'b1, 1'b1, 1'b0, '0);
    add_row(8'hff, 1'b1, 1'b1, 1'b0, '0);
    add_row(8'h55, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'haa, 1'b1, 1'b1, 1'b0, '0);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i]) begin
      if (directed_rows[i].has_check) typed_h0.push_back(directed_rows[i].digest_h0);
      send_item(directed_rows[i].data_byte, directed_rows[i].has_byte,
                directed_rows[i].end_of_message);
    end
    // Padding boundaries: lengths of 55, 56, 63 and 64 bytes.
    foreach (bound_lens[j]) begin
      len = bound_lens[j];
      for (int i = 0; i < len - 1; i++) send_item(8'($urandom), 1'b1, 1'b0);
      send_item(8'($urandom), 1'b1, 1'b1);
    end
    // Random messages, mostly short, with empty items mixed in.
    sent = 0;
    while (sent < RandomItems) begin
      no_idle = (sent > 20 && sent < 70);
      len = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(12);
      if (sent + len + 1 > RandomItems) len = RandomItems - sent - 1;
      for (int i = 0; i <= len; i++) begin
        db = 8'($urandom);
        if ($urandom_range(7) == 0) send_item(db, 1'b0, 1'b0);
        else begin
          send_item(db, (i < len) || $urandom_range(1), i == len);
          sent++;
        end
      end
    end
    in_valid_i <= 1'b0;
    stimulus_done = 1'b1;
  end

  // Long receiver hold-off, counted here, while the sender keeps offering.
  initial begin
    int unsigned held;
    hold_off = 1'b0;
    wait (rst_ni);
    repeat (30) @(posedge clk_i);
    held = 0;
    hold_off = 1'b1;
    while (held < 2000) begin
      @(posedge clk_i);
      held++;
    end
    hold_off = 1'b0;
  end

  // Receiver stall and digest checking.
  always @(posedge clk_i or negedge rst_ni) begin
    digest_xfer_t want;
    logic [31:0]  typed;
    if (!rst_ni) begin
      out_stall_i <= 1'b1;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_digests.size() == 0) begin
          $display("%0t: digest transfer with none expected: expected none actual %h",
                   $time, digest_word_o);
          fail_count++;
        end else begin
          want = pending_digests.pop_front();
          if (digest_word_o !== want.digest_word || word_index_o !== want.word_index ||
              last_word_o !== want.last_word) begin
            $display("%0t: mismatch expected %h/%0d/%0d actual %h/%0d/%0d", $time,
                     want.digest_word, want.word_index, want.last_word,
                     digest_word_o, word_index_o, last_word_o);
            fail_count++;
          end
          if (want.word_index == 3'd0 && typed_h0.size() > 0 && digest_count < 2) begin
            typed = typed_h0.pop_front();
            if (digest_word_o !== typed) begin
              $display("%0t: known digest H0 expected %h actual %h", $time, typed,
                       digest_word_o);
              fail_count++;
            end
          end
          if (want.last_word) digest_count++;
        end
      end
      out_stall_i <= hold_off || (!no_idle && $urandom_range(99) < 20);
    end
  end

  // Watchdog and end of run.
  initial begin
    idle_cycles = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("TEST FAILED");
        $finish;
      end
      if (stimulus_done && pending_digests.size() == 0) begin
        repeat (300) @(posedge clk_i);
        $display("Hashed %0d messages: empty, short, padding boundaries, multi-block,",
                 digest_count);
        $display("with random idling on both sides and one long output hold-off.");
        if (fail_count == 0) begin
          $display("TEST PASSED");
        end else begin
          $display("TEST FAILED");
        end
        $finish;
      end
    end
  end

endmodule
`default_nettype wire
